// ===== rtl/rgb_to_hsv_pixel_top_macros.svh =====
// Assertion macros for the checker in rtl/rgbhsv_check.sv.
// Each expects clk and rst in scope.
`ifndef RGB_TO_HSV_PIXEL_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define RGBHSV_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbhsv: assertion failed");

// Next-cycle implication, off during reset.
`define RGBHSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbhsv: assertion failed");

// What must hold in the cycle after reset is applied.
`define RGBHSV_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("rgbhsv: reset assertion failed");

`endif

// ===== rtl/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

  // Field widths
  localparam int CH_W    = 8;
  localparam int HUE_W   = 10;
  localparam int PCT_W   = 7;

  // Divider widths: hue numerator is below 360*255, saturation numerator below 100*256
  localparam int NUM_W     = 17;
  localparam int SAT_W     = 15;
  localparam int HUE_Q_W   = 9;
  localparam int SAT_Q_W   = 7;
  localparam int DIV_STEPS = HUE_Q_W;
  localparam int IDX_W     = 4;

  localparam logic [HUE_W-1:0]   HUE_GRAY  = '1;
  localparam logic [HUE_Q_W-1:0] HUE_LIMIT = HUE_Q_W'(359);

  typedef enum logic [1:0] {
    SEXT_RED   = 2'd0,
    SEXT_GREEN = 2'd1,
    SEXT_BLUE  = 2'd2
  } sextant_t;

  // Payload carried down the divider stages
  typedef struct packed {
    logic [NUM_W-1:0]   hue_rem;
    logic [CH_W-1:0]    delta;
    logic [SAT_W-1:0]   sat_rem;
    logic [CH_W-1:0]    mx;
    logic [HUE_Q_W-1:0] hue_q;
    logic [SAT_Q_W-1:0] sat_q;
    logic [PCT_W-1:0]   bright;
    logic               gray;
  } div_work_t;

  // floor(100*x/255): x*100 = 256*q0 + lo, so x*100 - 255*q0 = lo + q0 < 2*255
  function automatic logic [PCT_W-1:0] pct_of_255(input logic [CH_W-1:0] x);
    logic [SAT_W-1:0] v;
    logic [PCT_W-1:0] q0;
    logic [8:0]       rem;
    v   = SAT_W'(x) * SAT_W'(100);
    q0  = v[SAT_W-1:8];
    rem = {1'b0, v[7:0]} + 9'(q0);
    return (rem >= 9'd255) ? q0 + PCT_W'(1) : q0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbhsv_if.sv =====
`default_nettype none

// Pixel channel: one RGB pixel per beat
interface rgbhsv_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rgbhsv_pkg::CH_W-1:0] red;
  logic [rgbhsv_pkg::CH_W-1:0] green;
  logic [rgbhsv_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// HSV channel: one converted pixel per beat
interface rgbhsv_hsv_if;
  logic                                valid;
  logic                                ready;
  logic signed [rgbhsv_pkg::HUE_W-1:0] hue;
  logic        [rgbhsv_pkg::PCT_W-1:0] saturation;
  logic        [rgbhsv_pkg::PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel_top.sv =====
`default_nettype none

// RGB to HSV pixel converter. Takes one 8-bit RGB pixel per beat on pix and
// returns hue in whole degrees (0..359, or -1 for a gray pixel), saturation
// and brightness in percent (0..100) on hsv, in order. It accepts one pixel
// every clock unless stalled, via two front stages (max/min/sextant, then
// numerators and brightness) and a nine-stage restoring divider that
// retires one quotient bit per stage, hue and saturation side by side. Each
// stage holds its beat under backpressure and fills bubbles, so a waiting
// result does not block new pixels while any stage is empty.
module rgb_to_hsv_pixel_top (
  input  logic                clk,
  input  logic                rst,
  rgbhsv_pix_if.sink          pix,
  rgbhsv_hsv_if.source        hsv
);
  import rgbhsv_pkg::*;

  // Front stage 1 registers
  logic            f1_valid;
  logic            f1_ready;
  logic [CH_W-1:0] f1_red;
  logic [CH_W-1:0] f1_green;
  logic [CH_W-1:0] f1_blue;
  logic [CH_W-1:0] f1_mx;
  logic [CH_W-1:0] f1_delta;
  sextant_t        f1_sext;

  logic [CH_W-1:0] mx_next;
  logic [CH_W-1:0] mn_next;
  sextant_t        sext_next;

  // Front stage 2 registers
  logic            f2_valid;
  logic            f2_ready;
  div_work_t       f2_work;
  div_work_t       f2_work_next;
  logic [NUM_W-1:0] num;

  // Divider chain
  logic      [DIV_STEPS:0] chain_valid;
  logic      [DIV_STEPS:0] chain_ready;
  div_work_t               chain_work [DIV_STEPS+1];
  div_work_t               fin;

  // Max, min and sextant (red wins ties, then green)
  always_comb begin
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sext_next = SEXT_RED;
      mx_next   = pix.red;
    end else if (pix.green >= pix.blue) begin
      sext_next = SEXT_GREEN;
      mx_next   = pix.green;
    end else begin
      sext_next = SEXT_BLUE;
      mx_next   = pix.blue;
    end
    mn_next = pix.red;
    if (pix.green < mn_next) begin
      mn_next = pix.green;
    end
    if (pix.blue < mn_next) begin
      mn_next = pix.blue;
    end
  end

  assign f1_ready  = !f1_valid || f2_ready;
  assign pix.ready = f1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_ready) begin
      f1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && pix.valid) begin
      f1_red   <= pix.red;
      f1_green <= pix.green;
      f1_blue  <= pix.blue;
      f1_mx    <= mx_next;
      f1_delta <= mx_next - mn_next;
      f1_sext  <= sext_next;
    end
  end

  // Hue numerator per sextant, already wrapped to be non-negative
  always_comb begin
    case (f1_sext)
      SEXT_RED: begin
        if (f1_green >= f1_blue) begin
          num = NUM_W'(60) * (NUM_W'(f1_green) - NUM_W'(f1_blue));
        end else begin
          num = NUM_W'(360) * NUM_W'(f1_delta)
              - NUM_W'(60) * (NUM_W'(f1_blue) - NUM_W'(f1_green));
        end
      end
      SEXT_GREEN: begin
        num = NUM_W'(120) * NUM_W'(f1_delta) + NUM_W'(60) * NUM_W'(f1_blue)
            - NUM_W'(60) * NUM_W'(f1_red);
      end
      SEXT_BLUE: begin
        num = NUM_W'(240) * NUM_W'(f1_delta) + NUM_W'(60) * NUM_W'(f1_red)
            - NUM_W'(60) * NUM_W'(f1_green);
      end
      default: begin
        num = '0;
      end
    endcase

    f2_work_next.hue_rem = num;
    f2_work_next.delta   = f1_delta;
    f2_work_next.sat_rem = SAT_W'(f1_delta) * SAT_W'(100);
    f2_work_next.mx      = f1_mx;
    f2_work_next.hue_q   = '0;
    f2_work_next.sat_q   = '0;
    f2_work_next.bright  = pct_of_255(f1_mx);
    f2_work_next.gray    = (f1_delta == '0);
  end

  assign f2_ready = !f2_valid || chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_ready) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ready && f1_valid) begin
      f2_work <= f2_work_next;
    end
  end

  // Divider stages, MSB quotient bit first
  assign chain_valid[0] = f2_valid;
  assign chain_work[0]  = f2_work;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rgbhsv_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .bit_idx   (IDX_W'(DIV_STEPS - 1 - k)),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_work   (chain_work[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_work  (chain_work[k+1])
    );
  end

  // Result: gray override and hue clamp
  assign fin                     = chain_work[DIV_STEPS];
  assign chain_ready[DIV_STEPS]  = hsv.ready;
  assign hsv.valid               = chain_valid[DIV_STEPS];
  assign hsv.hue = fin.gray ? HUE_GRAY
                 : (fin.hue_q > HUE_LIMIT) ? HUE_W'(HUE_LIMIT)
                 : HUE_W'(fin.hue_q);
  assign hsv.saturation = fin.gray ? '0 : fin.sat_q;
  assign hsv.brightness = fin.bright;

endmodule

`default_nettype wire

// ===== rtl/rgbhsv_div_step.sv =====
`default_nettype none

// One restoring-division stage: retires one hue quotient bit and, in the
// low stages, one saturation quotient bit. Quotients shift in MSB first.
module rgbhsv_div_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rgbhsv_pkg::IDX_W-1:0]  bit_idx,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rgbhsv_pkg::div_work_t         in_work,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rgbhsv_pkg::div_work_t         out_work
);
  import rgbhsv_pkg::*;

  logic [NUM_W-1:0] hue_trial;
  logic [SAT_W-1:0] sat_trial;
  logic             hue_take;
  logic             sat_take;
  logic             sat_active;
  div_work_t        work_next;
  div_work_t        work;
  logic             valid;

  // Trial subtract of the shifted divisors
  always_comb begin
    hue_trial  = NUM_W'(in_work.delta) << bit_idx;
    sat_trial  = SAT_W'(in_work.mx) << bit_idx;
    sat_active = (bit_idx < IDX_W'(SAT_Q_W));
    hue_take   = (in_work.hue_rem >= hue_trial);
    sat_take   = sat_active && (in_work.sat_rem >= sat_trial);

    work_next       = in_work;
    work_next.hue_q = {in_work.hue_q[HUE_Q_W-2:0], hue_take};
    if (hue_take) begin
      work_next.hue_rem = in_work.hue_rem - hue_trial;
    end
    if (sat_active) begin
      work_next.sat_q = {in_work.sat_q[SAT_Q_W-2:0], sat_take};
    end
    if (sat_take) begin
      work_next.sat_rem = in_work.sat_rem - sat_trial;
    end
  end

  // Stage handshake: take a beat when empty or when downstream drains
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work <= work_next;
    end
  end

  assign out_valid = valid;
  assign out_work  = work;

endmodule

`default_nettype wire

// ===== rtl/rgbhsv_check.sv =====
`default_nettype none

// Port-level checks of the converter
module rgbhsv_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rgbhsv_pkg::HUE_W-1:0]  hue,
  input logic [rgbhsv_pkg::PCT_W-1:0]  sat,
  input logic [rgbhsv_pkg::PCT_W-1:0]  bright
);
  import rgbhsv_pkg::*;
  `include "rgb_to_hsv_pixel_top_macros.svh"

  logic out_in_range;

  // Hue 0..359 or gray, percentages 0..100
  assign out_in_range = (hue == HUE_GRAY || hue < HUE_W'(360))
                     && sat <= PCT_W'(100) && bright <= PCT_W'(100);

  // Reset empties the pipe and opens the input
  `RGBHSV_ASSERT_RESET(a_reset_empty, !out_valid && in_ready)

  // A stalled result beat stays up
  `RGBHSV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Gray pixels carry zero saturation
  `RGBHSV_ASSERT(a_gray_sat, out_valid && hue == HUE_GRAY, sat == '0)

  // Hue and percentages stay in range
  `RGBHSV_ASSERT(a_ranges, out_valid, out_in_range)

endmodule

bind rgb_to_hsv_pixel_top rgbhsv_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix.ready),
  .out_valid (hsv.valid),
  .out_ready (hsv.ready),
  .hue       (hsv.hue),
  .sat       (hsv.saturation),
  .bright    (hsv.brightness)
);

`default_nettype wire

// ===== sim/hsv_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel and HSV channels, predicts each converted pixel and
// compares every returned beat against the oldest prediction.
module hsv_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  input  logic                             pix_ready,
  input  logic [rgbhsv_pkg::CH_W-1:0]      red,
  input  logic [rgbhsv_pkg::CH_W-1:0]      green,
  input  logic [rgbhsv_pkg::CH_W-1:0]      blue,
  input  logic                             hsv_valid,
  input  logic                             hsv_ready,
  input  logic signed [rgbhsv_pkg::HUE_W-1:0] hue,
  input  logic [rgbhsv_pkg::PCT_W-1:0]     saturation,
  input  logic [rgbhsv_pkg::PCT_W-1:0]     brightness,
  output int                               pending,
  output int                               fail_count
);
  import rgbhsv_pkg::*;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [PCT_W-1:0]        saturation;
    logic [PCT_W-1:0]        brightness;
  } hsv_beat_t;

  hsv_beat_t expected_hsv[$];
  int        mismatches = 0;

  // Exact integer HSV conversion of one pixel
  function automatic hsv_beat_t predict_hsv(input logic [CH_W-1:0] r8, g8, b8);
    int        r, g, b, mx, mn, delta, num, q;
    sextant_t  sext;
    hsv_beat_t res;
    r  = int'(r8);
    g  = int'(g8);
    b  = int'(b8);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res.brightness = PCT_W'((100 * mx) / 255);
    if (delta == 0) begin
      // gray: no chroma, hue flagged
      res.hue        = HUE_GRAY;
      res.saturation = '0;
    end else begin
      res.saturation = PCT_W'((100 * delta) / mx);
      // red wins ties, then green
      if (r == mx)      sext = SEXT_RED;
      else if (g == mx) sext = SEXT_GREEN;
      else              sext = SEXT_BLUE;
      case (sext)
        SEXT_RED: begin
          num = 60 * (g - b);
          if (num < 0) num += 360 * delta;
        end
        SEXT_GREEN: num = 120 * delta + 60 * (b - r);
        default:    num = 240 * delta + 60 * (r - g);
      endcase
      q = num / delta;
      if (q >= 360) q = 359;
      res.hue = HUE_W'(q);
    end
    return res;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t hsv_checker: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Result side first, then queue the prediction for the accepted pixel
  always @(posedge clk) begin
    hsv_beat_t want;
    if (rst) begin
      expected_hsv.delete();
    end else begin
      if (hsv_valid && hsv_ready) begin
        if (expected_hsv.size() == 0) begin
          $display("%0t hsv_checker: unexpected beat, expected none, got hue %0d sat %0d val %0d",
                   $time, hue, saturation, brightness);
          mismatches++;
        end else begin
          want = expected_hsv.pop_front();
          if (hue !== want.hue) report_field("hue", want.hue, hue);
          if (saturation !== want.saturation)
            report_field("saturation", want.saturation, saturation);
          if (brightness !== want.brightness)
            report_field("brightness", want.brightness, brightness);
        end
      end
      if (pix_valid && pix_ready) expected_hsv.push_back(predict_hsv(red, green, blue));
    end
    pending    <= expected_hsv.size();
    fail_count <= mismatches;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rgbhsv_pkg::*;

  localparam int RANDOM_PIXELS = 1750;
  localparam int MAX_GAP       = 18;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 30;

  logic clk;
  logic rst;
  logic calm;  // when set, neither side idles
  int   pending;
  int   fail_count;
  int   cycle_cnt;

  rgbhsv_pix_if pix_ch ();
  rgbhsv_hsv_if hsv_ch ();

  rgb_to_hsv_pixel_top DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .hsv (hsv_ch)
  );

  hsv_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_ch.valid),
    .pix_ready  (pix_ch.ready),
    .red        (pix_ch.red),
    .green      (pix_ch.green),
    .blue       (pix_ch.blue),
    .hsv_valid  (hsv_ch.valid),
    .hsv_ready  (hsv_ch.ready),
    .hue        (hsv_ch.hue),
    .saturation (hsv_ch.saturation),
    .brightness (hsv_ch.brightness),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One pixel beat, after a random gap unless calm is set
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Hold the pixel side until every predicted beat has come back
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    logic [31:0]     v;
    logic [CH_W-1:0] r, g, b;
    int              kind;
    rst          = 1'b1;
    calm         = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red   = '0;
    pix_ch.green = '0;
    pix_ch.blue  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: black, white, gray, primaries, max ties, hue wrap, small values
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'd2,   8'd1,   8'd1);
    send_pixel(8'd170, 8'd85,  8'd255);
    wait_drained();

    // random pixels, with gray, tie-heavy and small-value mixes
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PIXELS / 2) wait_drained();
      v    = $urandom;
      r    = v[7:0];
      g    = v[15:8];
      b    = v[23:16];
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          g = r;
          b = CH_W'($urandom_range(0, r));
        end
        2: begin
          b = g;
          r = CH_W'($urandom_range(0, g));
        end
        3: begin
          b = r;
          g = CH_W'($urandom_range(0, r));
        end
        4: begin
          r = r & 8'h07;
          g = g & 8'h07;
          b = b & 8'h07;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Result side: random stall per beat unless calm is set
  initial begin
    int stall;
    hsv_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        hsv_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsv_ch.ready <= 1'b1;
      do @(posedge clk); while (!hsv_ch.valid);
    end
  end

  // Timeout
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
